// ----- sv/trcpu_pkg.sv -----
// shared constants, codes and types of the two-register machine
`timescale 1ns / 1ps

package trcpu_pkg;

    // store geometry
    localparam int MEMORY_DEPTH = 4096;
    localparam int ADDR_W       = $clog2(MEMORY_DEPTH);

    // field widths
    localparam int WORD_W   = 32;
    localparam int PLEN_W   = 13;
    localparam int LADDR_W  = 12;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 3;
    localparam int OP_W     = 8;
    localparam int ARG_W    = 24;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_STEP    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RESTART = 2'd2;

    // instruction opcodes
    localparam logic [OP_W-1:0] OP_LDC  = 8'd0;
    localparam logic [OP_W-1:0] OP_ADC  = 8'd1;
    localparam logic [OP_W-1:0] OP_LDL  = 8'd2;
    localparam logic [OP_W-1:0] OP_STL  = 8'd3;
    localparam logic [OP_W-1:0] OP_LDNL = 8'd4;
    localparam logic [OP_W-1:0] OP_STNL = 8'd5;
    localparam logic [OP_W-1:0] OP_ADD  = 8'd6;
    localparam logic [OP_W-1:0] OP_SUB  = 8'd7;
    localparam logic [OP_W-1:0] OP_SHL  = 8'd8;
    localparam logic [OP_W-1:0] OP_SHR  = 8'd9;
    localparam logic [OP_W-1:0] OP_ADJ  = 8'd10;
    localparam logic [OP_W-1:0] OP_A2SP = 8'd11;
    localparam logic [OP_W-1:0] OP_SP2A = 8'd12;
    localparam logic [OP_W-1:0] OP_CALL = 8'd13;
    localparam logic [OP_W-1:0] OP_RET  = 8'd14;
    localparam logic [OP_W-1:0] OP_BRZ  = 8'd15;
    localparam logic [OP_W-1:0] OP_BRLZ = 8'd16;
    localparam logic [OP_W-1:0] OP_BR   = 8'd17;
    localparam logic [OP_W-1:0] OP_HALT = 8'd18;
    localparam logic [OP_W-1:0] OP_SET  = 8'd19;
    localparam logic [OP_W-1:0] OP_DATA = 8'd20;

    // run status
    typedef enum logic [STATUS_W-1:0] {
        ST_RUN     = 3'd0,
        ST_HALT    = 3'd1,
        ST_INVALID = 3'd2,
        ST_BADMEM  = 3'd3,
        ST_PCRANGE = 3'd4,
        ST_END     = 3'd5
    } t_status;

    // sequencer states
    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_state;

    // instruction store access
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [WORD_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } t_imem_req;

    // data store access
    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] wdata;
    } t_dmem_req;

endpackage

// ----- sv/trcpu_if.sv -----
// channel interfaces: item input, result output, configuration write
`timescale 1ns / 1ps

interface trcpu_in_if;
    logic                               valid;
    logic                               ready;
    logic [trcpu_pkg::KIND_W-1:0]       opcode;
    logic [trcpu_pkg::LADDR_W-1:0]      load_address;
    logic [trcpu_pkg::WORD_W-1:0]       load_word;

    modport source (output valid, opcode, load_address, load_word, input ready);
    modport sink   (input valid, opcode, load_address, load_word, output ready);
endinterface

interface trcpu_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [trcpu_pkg::WORD_W-1:0] pc_value;
    logic signed [trcpu_pkg::WORD_W-1:0] sp_value;
    logic signed [trcpu_pkg::WORD_W-1:0] a_value;
    logic signed [trcpu_pkg::WORD_W-1:0] b_value;
    logic [trcpu_pkg::STATUS_W-1:0]      run_status;
    logic [trcpu_pkg::WORD_W-1:0]        executed_count;

    modport source (output valid, pc_value, sp_value, a_value, b_value, run_status,
                    executed_count, input ready);
    modport sink   (input valid, pc_value, sp_value, a_value, b_value, run_status,
                    executed_count, output ready);
endinterface

interface trcpu_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [trcpu_pkg::PLEN_W-1:0]  data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ----- sv/trcpu_imem.sv -----
// instruction store: one write port, one registered read port
`timescale 1ns / 1ps

module trcpu_imem (
    input  logic                             i_clk,
    input  trcpu_pkg::t_imem_req             i_req,
    output logic [trcpu_pkg::WORD_W-1:0]     o_rdata
);

    logic [trcpu_pkg::WORD_W-1:0] mem [trcpu_pkg::MEMORY_DEPTH];
    logic [trcpu_pkg::WORD_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // read port, read every cycle
    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/trcpu_dmem.sv -----
// data store with a clearing sweep after reset
`timescale 1ns / 1ps

module trcpu_dmem (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  trcpu_pkg::t_dmem_req             i_req,
    output logic [trcpu_pkg::WORD_W-1:0]     o_rdata,
    output logic                             o_clear_busy
);

    logic [trcpu_pkg::WORD_W-1:0] mem [trcpu_pkg::MEMORY_DEPTH];
    logic [trcpu_pkg::WORD_W-1:0] r_rdata;
    logic [trcpu_pkg::ADDR_W-1:0] r_clr_addr;
    logic [trcpu_pkg::ADDR_W-1:0] n_clr_addr;
    logic                         r_clr_busy;
    logic                         n_clr_busy;

    // sweep counter
    always_comb begin
        n_clr_addr = r_clr_addr;
        n_clr_busy = r_clr_busy;
        if (r_clr_busy) begin
            n_clr_addr = r_clr_addr + 1'b1;
            if (r_clr_addr == trcpu_pkg::ADDR_W'(trcpu_pkg::MEMORY_DEPTH - 1)) begin
                n_clr_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_clr_busy <= 1'b1;
        end else begin
            r_clr_addr <= n_clr_addr;
            r_clr_busy <= n_clr_busy;
        end
    end

    // write port, the sweep has priority
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            mem[r_clr_addr] <= '0;
        end else if (i_req.we) begin
            mem[i_req.addr] <= i_req.wdata;
        end
    end

    // read port
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= mem[i_req.addr];
        end
    end

    assign o_rdata      = r_rdata;
    assign o_clear_busy = r_clr_busy;

endmodule

// ----- sv/two_register_cpu_step.sv -----
// top level: item sequencer, machine registers and result register
//
// Two-register accumulator machine driven one item at a time.
// i_in carries items: load a word into both stores, execute one
// instruction at PC, restart the registers or only report them. Every
// item gives exactly one beat on o_out holding PC, SP, A, B, run status
// and the executed instruction count after the item. i_cfg writes program_length.
// An accepted item sits in an input register; a load, restart or report
// item, or a step that cannot run, is handled once the result slot is
// free, and its beat is registered in the result register. A step that
// runs first reads the data store at the operand address of the
// prefetched instruction, then executes and writes back in S_EXEC once
// the result slot is free. The instruction at PC is read ahead every
// cycle; a new item is taken only as the last one finishes, and a load
// that writes the word at PC forces a refetch before the next step.
// After reset the data store is swept to zero, one word a cycle, over
// all 4096 words; no item is taken meanwhile, configuration writes are.
// When o_out stalls, the finished beat is held, one further item may
// wait in the input register and the sequencer pauses.
`timescale 1ns / 1ps

module two_register_cpu_step (
    input  logic              i_clk,
    input  logic              i_rst_n,
    trcpu_in_if.sink          i_in,
    trcpu_out_if.source       o_out,
    trcpu_cfg_if.sink         i_cfg
);

    localparam int W = trcpu_pkg::WORD_W;
    localparam int A = trcpu_pkg::ADDR_W;

    trcpu_pkg::t_state  r_state, n_state;
    trcpu_pkg::t_status r_status, n_status;

    // input register
    logic                             r_in_valid;
    logic [trcpu_pkg::KIND_W-1:0]     r_in_kind;
    logic [trcpu_pkg::LADDR_W-1:0]    r_in_addr;
    logic [W-1:0]                     r_in_word;

    // machine registers
    logic [W-1:0] r_pc, n_pc, r_sp, n_sp, r_a, n_a, r_b, n_b, r_cnt, n_cnt;
    logic [trcpu_pkg::PLEN_W-1:0] r_plen;
    logic r_iq_ok, n_iq_ok;

    // decoded instruction held for execute
    logic [trcpu_pkg::OP_W-1:0] r_ex_op, n_ex_op;
    logic [W-1:0]               r_ex_arg, n_ex_arg;
    logic [A-1:0]               r_ex_addr, n_ex_addr;
    logic                       r_ex_ok, n_ex_ok;

    // result register
    logic                             r_out_valid;
    logic [W-1:0]                     r_out_pc, r_out_sp, r_out_a, r_out_b, r_out_cnt;
    logic [trcpu_pkg::STATUS_W-1:0]   r_out_status;

    trcpu_pkg::t_imem_req imem_req;
    trcpu_pkg::t_dmem_req dmem_req;
    logic [W-1:0]         iq_word;
    logic [W-1:0]         dq_word;
    logic                 clear_busy;

    logic                        slot_free;
    logic                        done;
    logic                        in_beat;
    logic                        load_ok;
    logic                        pc_end;
    logic                        pc_big;
    logic [trcpu_pkg::OP_W-1:0]  f_op;
    logic [W-1:0]                f_arg;
    logic [W-1:0]                f_base;
    logic [W:0]                  f_sum;
    logic                        f_ok;

    trcpu_imem u_imem (
        .i_clk   (i_clk),
        .i_req   (imem_req),
        .o_rdata (iq_word)
    );

    trcpu_dmem u_dmem (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (dmem_req),
        .o_rdata      (dq_word),
        .o_clear_busy (clear_busy)
    );

    // handshakes
    assign slot_free   = !r_out_valid || o_out.ready;
    assign i_in.ready  = (r_state != trcpu_pkg::S_CLEAR) && (!r_in_valid || done);
    assign in_beat     = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    // decode of the prefetched word and its data address
    assign f_op   = iq_word[trcpu_pkg::OP_W-1:0];
    assign f_arg  = W'($signed(iq_word[W-1:trcpu_pkg::OP_W]));
    assign f_base = (f_op == trcpu_pkg::OP_LDL || f_op == trcpu_pkg::OP_STL) ? r_sp : r_a;
    assign f_sum  = {f_base[W-1], f_base} + {f_arg[W-1], f_arg};
    assign f_ok   = !f_sum[W] && (f_sum < (W + 1)'(trcpu_pkg::MEMORY_DEPTH));

    assign pc_end  = r_pc >= W'(r_plen);
    assign pc_big  = r_pc >= W'(trcpu_pkg::MEMORY_DEPTH);
    assign load_ok = W'(r_in_addr) < W'(trcpu_pkg::MEMORY_DEPTH);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            trcpu_pkg::S_CLEAR: begin
                if (!clear_busy) begin
                    n_state = trcpu_pkg::S_IDLE;
                end
            end
            trcpu_pkg::S_IDLE: begin
                if (r_in_valid && r_in_kind == trcpu_pkg::KIND_STEP &&
                    r_status == trcpu_pkg::ST_RUN && !pc_end && !pc_big && r_iq_ok) begin
                    n_state = trcpu_pkg::S_EXEC;
                end
            end
            trcpu_pkg::S_EXEC: begin
                if (slot_free) begin
                    n_state = trcpu_pkg::S_IDLE;
                end
            end
            default: n_state = trcpu_pkg::S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        logic [W-1:0] v_pc;
        logic         v_stop;

        n_pc      = r_pc;
        n_sp      = r_sp;
        n_a       = r_a;
        n_b       = r_b;
        n_cnt     = r_cnt;
        n_status  = r_status;
        n_ex_op   = r_ex_op;
        n_ex_arg  = r_ex_arg;
        n_ex_addr = r_ex_addr;
        n_ex_ok   = r_ex_ok;
        done      = 1'b0;
        v_pc      = r_pc;
        v_stop    = 1'b0;
        imem_req.we    = 1'b0;
        imem_req.waddr = A'(r_in_addr);
        imem_req.wdata = r_in_word;
        dmem_req.we    = 1'b0;
        dmem_req.re    = 1'b0;
        dmem_req.addr  = A'(r_in_addr);
        dmem_req.wdata = r_in_word;

        unique case (r_state)
            trcpu_pkg::S_IDLE: begin
                if (r_in_valid) begin
                    case (r_in_kind)
                        trcpu_pkg::KIND_LOAD: begin
                            if (slot_free) begin
                                done        = 1'b1;
                                imem_req.we = load_ok;
                                dmem_req.we = load_ok;
                            end
                        end
                        trcpu_pkg::KIND_RESTART: begin
                            if (slot_free) begin
                                done     = 1'b1;
                                n_pc     = '0;
                                n_sp     = '0;
                                n_a      = '0;
                                n_b      = '0;
                                n_cnt    = '0;
                                n_status = trcpu_pkg::ST_RUN;
                            end
                        end
                        trcpu_pkg::KIND_STEP: begin
                            if (r_status != trcpu_pkg::ST_RUN) begin
                                done = slot_free;
                            end else if (pc_end) begin
                                if (slot_free) begin
                                    done     = 1'b1;
                                    n_status = trcpu_pkg::ST_END;
                                end
                            end else if (pc_big) begin
                                if (slot_free) begin
                                    done     = 1'b1;
                                    n_status = trcpu_pkg::ST_PCRANGE;
                                end
                            end else if (r_iq_ok) begin
                                // operand read of the prefetched instruction
                                dmem_req.re   = f_ok;
                                dmem_req.addr = f_sum[A-1:0];
                                n_ex_op       = f_op;
                                n_ex_arg      = f_arg;
                                n_ex_addr     = f_sum[A-1:0];
                                n_ex_ok       = f_ok;
                            end
                        end
                        default: begin
                            done = slot_free;
                        end
                    endcase
                end
            end
            trcpu_pkg::S_EXEC: begin
                if (slot_free) begin
                    done          = 1'b1;
                    dmem_req.addr = r_ex_addr;
                    if (r_cnt != '1) begin
                        n_cnt = r_cnt + 1'b1;
                    end
                    case (r_ex_op)
                        trcpu_pkg::OP_LDC: begin
                            n_b = r_a;
                            n_a = r_ex_arg;
                        end
                        trcpu_pkg::OP_ADC: n_a = r_a + r_ex_arg;
                        trcpu_pkg::OP_LDL: begin
                            n_b = r_a;
                            if (r_ex_ok) begin
                                n_a = dq_word;
                            end else begin
                                n_status = trcpu_pkg::ST_BADMEM;
                                v_stop   = 1'b1;
                            end
                        end
                        trcpu_pkg::OP_STL: begin
                            if (r_ex_ok) begin
                                dmem_req.we    = 1'b1;
                                dmem_req.wdata = r_a;
                                n_a            = r_b;
                            end else begin
                                n_status = trcpu_pkg::ST_BADMEM;
                                v_stop   = 1'b1;
                            end
                        end
                        trcpu_pkg::OP_LDNL: begin
                            if (r_ex_ok) begin
                                n_a = dq_word;
                            end else begin
                                n_status = trcpu_pkg::ST_BADMEM;
                                v_stop   = 1'b1;
                            end
                        end
                        trcpu_pkg::OP_STNL: begin
                            if (r_ex_ok) begin
                                dmem_req.we    = 1'b1;
                                dmem_req.wdata = r_b;
                            end else begin
                                n_status = trcpu_pkg::ST_BADMEM;
                                v_stop   = 1'b1;
                            end
                        end
                        trcpu_pkg::OP_ADD:  n_a = r_b + r_a;
                        trcpu_pkg::OP_SUB:  n_a = r_b - r_a;
                        trcpu_pkg::OP_SHL:  n_a = r_b << r_a[4:0];
                        trcpu_pkg::OP_SHR:  n_a = W'($signed(r_b) >>> r_a[4:0]);
                        trcpu_pkg::OP_ADJ:  n_sp = r_sp + r_ex_arg;
                        trcpu_pkg::OP_A2SP: begin
                            n_sp = r_a;
                            n_a  = r_b;
                        end
                        trcpu_pkg::OP_SP2A: begin
                            n_b = r_a;
                            n_a = r_sp;
                        end
                        trcpu_pkg::OP_CALL: begin
                            n_b  = r_a;
                            n_a  = r_pc;
                            v_pc = r_pc + r_ex_arg;
                        end
                        trcpu_pkg::OP_RET: begin
                            v_pc = r_a;
                            n_a  = r_b;
                        end
                        trcpu_pkg::OP_BRZ: begin
                            if (r_a == '0) begin
                                v_pc = r_pc + r_ex_arg;
                            end
                        end
                        trcpu_pkg::OP_BRLZ: begin
                            if (r_a[W-1]) begin
                                v_pc = r_pc + r_ex_arg;
                            end
                        end
                        trcpu_pkg::OP_BR:   v_pc = r_pc + r_ex_arg;
                        trcpu_pkg::OP_HALT: begin
                            n_status = trcpu_pkg::ST_HALT;
                            v_stop   = 1'b1;
                        end
                        trcpu_pkg::OP_SET, trcpu_pkg::OP_DATA: begin
                            n_status = trcpu_pkg::ST_INVALID;
                            v_stop   = 1'b1;
                        end
                        default: ;
                    endcase
                    // pc update and end of program
                    if (!v_stop) begin
                        if (v_pc >= W'(r_plen) || v_pc >= W'(trcpu_pkg::MEMORY_DEPTH)) begin
                            n_pc     = v_pc;
                            n_status = trcpu_pkg::ST_PCRANGE;
                        end else begin
                            n_pc = v_pc + 1'b1;
                            if (v_pc + 1'b1 >= W'(r_plen)) begin
                                n_status = trcpu_pkg::ST_END;
                            end
                        end
                    end
                end
            end
            default: ;
        endcase

        // prefetch the word at the next pc
        imem_req.raddr = n_pc[A-1:0];
    end

    // prefetched word is stale when a load hits the same address
    assign n_iq_ok = !(imem_req.we && imem_req.waddr == imem_req.raddr);

    // control and machine registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= trcpu_pkg::S_CLEAR;
            r_status    <= trcpu_pkg::ST_RUN;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_iq_ok     <= 1'b0;
            r_pc        <= '0;
            r_sp        <= '0;
            r_a         <= '0;
            r_b         <= '0;
            r_cnt       <= '0;
            r_plen      <= '0;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
            r_iq_ok  <= n_iq_ok;
            r_pc     <= n_pc;
            r_sp     <= n_sp;
            r_a      <= n_a;
            r_b      <= n_b;
            r_cnt    <= n_cnt;
            if (in_beat) begin
                r_in_valid <= 1'b1;
            end else if (done) begin
                r_in_valid <= 1'b0;
            end
            if (done) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg.valid && i_cfg.ready) begin
                r_plen <= i_cfg.data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_in_kind <= i_in.opcode;
            r_in_addr <= i_in.load_address;
            r_in_word <= i_in.load_word;
        end
        r_ex_op   <= n_ex_op;
        r_ex_arg  <= n_ex_arg;
        r_ex_addr <= n_ex_addr;
        r_ex_ok   <= n_ex_ok;
        if (done) begin
            r_out_pc     <= n_pc;
            r_out_sp     <= n_sp;
            r_out_a      <= n_a;
            r_out_b      <= n_b;
            r_out_cnt    <= n_cnt;
            r_out_status <= n_status;
        end
    end

    // result channel
    assign o_out.valid          = r_out_valid;
    assign o_out.pc_value       = r_out_pc;
    assign o_out.sp_value       = r_out_sp;
    assign o_out.a_value        = r_out_a;
    assign o_out.b_value        = r_out_b;
    assign o_out.run_status     = r_out_status;
    assign o_out.executed_count = r_out_cnt;

`ifndef NO_ASSERTIONS
    // no item enters while the data store is being swept
    a_no_item_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == trcpu_pkg::S_CLEAR |-> !i_in.ready)
        else $error("item taken during data store sweep");

    // execute returns to idle once the result slot is free
    a_exec_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == trcpu_pkg::S_EXEC && (!r_out_valid || o_out.ready))
        |=> r_state == trcpu_pkg::S_IDLE)
        else $error("execute did not retire");

    // execute only ever works on a held step item
    a_exec_has_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == trcpu_pkg::S_EXEC |-> r_in_valid && r_in_kind == trcpu_pkg::KIND_STEP)
        else $error("execute without a step item");

    // data store never read and written in the same cycle
    a_dmem_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dmem_req.re |-> !dmem_req.we)
        else $error("data store read and write collide");
`endif

endmodule

// ----- dv/testbench.sv -----
// testbench for two_register_cpu_step: directed table, then random programs checked by a predictor
`timescale 1ns / 1ps

module testbench;
    import trcpu_pkg::*;

    // item kind the block does not decode: it only reports the state
    localparam logic [KIND_W-1:0] KIND_REPORT    = 2'd3;
    localparam logic [OP_W-1:0]   OP_TOP         = 8'hFF;
    localparam int unsigned       RANDOM_ITEMS   = 1600;
    localparam int unsigned       QUIET_ITEMS    = 200;
    localparam int unsigned       WATCHDOG_LIMIT = 25000;

    typedef struct {
        logic [WORD_W-1:0] pc;
        logic [WORD_W-1:0] sp;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        t_status           st;
        logic [WORD_W-1:0] cnt;
    } machine_state_t;

    typedef struct {
        bit                 is_cfg;
        logic [KIND_W-1:0]  kind;
        logic [LADDR_W-1:0] addr;
        logic [WORD_W-1:0]  word;
        bit                 typed;
        machine_state_t     exp;
    } table_row_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    trcpu_in_if  in_ch ();
    trcpu_out_if out_ch ();
    trcpu_cfg_if cfg_ch ();

    two_register_cpu_step dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // predicted machine state
    logic [WORD_W-1:0] m_code [MEMORY_DEPTH];
    logic [WORD_W-1:0] m_data [MEMORY_DEPTH];
    bit                code_loaded [MEMORY_DEPTH];
    logic [WORD_W-1:0] m_pc, m_sp, m_a, m_b, m_count;
    t_status           m_status;
    logic [PLEN_W-1:0] m_plen;

    machine_state_t reports_due [$];
    machine_state_t want;

    int unsigned fail_count     = 0;
    int unsigned beats_checked  = 0;
    int unsigned instr_executed = 0;
    int unsigned stops_seen     = 0;
    int unsigned plen_writes    = 0;
    int unsigned random_count   = 0;
    int unsigned idle_pct       = 0;
    int unsigned stall_pct      = 0;
    int unsigned stall_left     = 0;
    int unsigned idle_cycles    = 0;
    bit          quiet          = 1'b0;

    always #5 i_clk = ~i_clk;

    // address check for data accesses: base plus operand, both signed
    function automatic bit data_addr(input logic [WORD_W-1:0] base,
                                     input logic [WORD_W-1:0] off,
                                     output logic [ADDR_W-1:0] ea);
        logic signed [WORD_W+1:0] sum;
        sum = {{2{base[WORD_W-1]}}, base} + {{2{off[WORD_W-1]}}, off};
        ea  = sum[ADDR_W-1:0];
        return (sum >= 0 && sum < MEMORY_DEPTH);
    endfunction

    // one instruction at pc
    function automatic void exec_word();
        logic [WORD_W-1:0] cur, npc, word, arg;
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] ea;
        cur = m_pc;
        if (cur >= m_plen) begin
            m_status = ST_END;
            return;
        end
        if (cur >= 32'(MEMORY_DEPTH)) begin
            m_status = ST_PCRANGE;
            return;
        end
        if (m_count != '1)
            m_count = m_count + 1;
        instr_executed++;
        word = m_code[cur[ADDR_W-1:0]];
        op   = word[OP_W-1:0];
        arg  = {{(WORD_W-ARG_W){word[WORD_W-1]}}, word[WORD_W-1:OP_W]};
        npc  = cur;
        case (op)
            OP_LDC: begin
                m_b = m_a;
                m_a = arg;
            end
            OP_ADC: m_a = m_a + arg;
            OP_LDL: begin
                // b takes a even when the access faults
                m_b = m_a;
                if (!data_addr(m_sp, arg, ea)) begin
                    m_status = ST_BADMEM;
                    return;
                end
                m_a = m_data[ea];
            end
            OP_STL: begin
                if (!data_addr(m_sp, arg, ea)) begin
                    m_status = ST_BADMEM;
                    return;
                end
                m_data[ea] = m_a;
                m_a = m_b;
            end
            OP_LDNL: begin
                if (!data_addr(m_a, arg, ea)) begin
                    m_status = ST_BADMEM;
                    return;
                end
                m_a = m_data[ea];
            end
            OP_STNL: begin
                if (!data_addr(m_a, arg, ea)) begin
                    m_status = ST_BADMEM;
                    return;
                end
                m_data[ea] = m_b;
            end
            OP_ADD:  m_a = m_b + m_a;
            OP_SUB:  m_a = m_b - m_a;
            OP_SHL:  m_a = m_b << m_a[4:0];
            OP_SHR:  m_a = $signed(m_b) >>> m_a[4:0];
            OP_ADJ:  m_sp = m_sp + arg;
            OP_A2SP: begin
                m_sp = m_a;
                m_a  = m_b;
            end
            OP_SP2A: begin
                m_b = m_a;
                m_a = m_sp;
            end
            OP_CALL: begin
                m_b = m_a;
                m_a = cur;
                npc = cur + arg;
            end
            OP_RET: begin
                npc = m_a;
                m_a = m_b;
            end
            OP_BRZ:  if (m_a == '0) npc = cur + arg;
            OP_BRLZ: if (m_a[WORD_W-1]) npc = cur + arg;
            OP_BR:   npc = cur + arg;
            OP_HALT: begin
                m_status = ST_HALT;
                return;
            end
            OP_SET, OP_DATA: begin
                m_status = ST_INVALID;
                return;
            end
            default: ;
        endcase
        // target outside the program or the store stops with pc on the target
        if (npc >= m_plen || npc >= 32'(MEMORY_DEPTH)) begin
            m_pc     = npc;
            m_status = ST_PCRANGE;
            return;
        end
        m_pc = npc + 1;
        if (m_pc >= m_plen)
            m_status = ST_END;
    endfunction

    // state after one item
    function automatic machine_state_t apply_item(input logic [KIND_W-1:0] kind,
                                                  input logic [LADDR_W-1:0] addr,
                                                  input logic [WORD_W-1:0] word);
        machine_state_t s;
        case (kind)
            KIND_LOAD: begin
                m_code[addr]      = word;
                m_data[addr]      = word;
                code_loaded[addr] = 1'b1;
            end
            KIND_STEP: begin
                if (m_status == ST_RUN) begin
                    exec_word();
                    if (m_status != ST_RUN)
                        stops_seen++;
                end
            end
            KIND_RESTART: begin
                m_pc     = '0;
                m_sp     = '0;
                m_a      = '0;
                m_b      = '0;
                m_count  = '0;
                m_status = ST_RUN;
            end
            default: ;
        endcase
        s.pc  = m_pc;
        s.sp  = m_sp;
        s.a   = m_a;
        s.b   = m_b;
        s.st  = m_status;
        s.cnt = m_count;
        return s;
    endfunction

    function automatic logic [WORD_W-1:0] rand_instr(input int unsigned span);
        logic [OP_W-1:0]  op;
        logic [ARG_W-1:0] arg;
        int unsigned      pick;
        pick = $urandom_range(0, 99);
        if (pick < 86)
            op = OP_W'($urandom_range(OP_LDC, OP_HALT));
        else if (pick < 92)
            op = OP_W'($urandom_range(OP_SET, OP_DATA));
        else
            op = OP_W'($urandom_range(OP_DATA + 1, OP_TOP));
        case ($urandom_range(0, 11))
            0:       arg = ARG_W'($urandom);
            1:       arg = 24'h7F_FFFF;
            2:       arg = 24'h80_0000;
            default: arg = ARG_W'($urandom_range(0, 2 * span)) - ARG_W'(span);
        endcase
        return {arg, op};
    endfunction

    function automatic table_row_t item_row(input logic [KIND_W-1:0] kind,
                                            input logic [LADDR_W-1:0] addr,
                                            input logic [WORD_W-1:0] word);
        table_row_t r;
        r.is_cfg = 1'b0;
        r.kind   = kind;
        r.addr   = addr;
        r.word   = word;
        r.typed  = 1'b0;
        return r;
    endfunction

    function automatic table_row_t check_row(input logic [KIND_W-1:0] kind,
                                             input logic [WORD_W-1:0] pc,
                                             input logic [WORD_W-1:0] sp,
                                             input logic [WORD_W-1:0] a,
                                             input logic [WORD_W-1:0] b,
                                             input t_status st,
                                             input logic [WORD_W-1:0] cnt);
        table_row_t r;
        r         = item_row(kind, '0, '0);
        r.typed   = 1'b1;
        r.exp.pc  = pc;
        r.exp.sp  = sp;
        r.exp.a   = a;
        r.exp.b   = b;
        r.exp.st  = st;
        r.exp.cnt = cnt;
        return r;
    endfunction

    function automatic table_row_t plen_row(input logic [PLEN_W-1:0] value);
        table_row_t r;
        r        = item_row(KIND_REPORT, '0, WORD_W'(value));
        r.is_cfg = 1'b1;
        return r;
    endfunction

    // program length is written only once every beat has come back
    task automatic write_plen(input logic [PLEN_W-1:0] value);
        in_ch.valid <= 1'b0;
        while (reports_due.size() != 0)
            @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        m_plen = value;
        plen_writes++;
    endtask

    // drive one item, predict at acceptance; valid stays high for a following item
    task automatic run_item(input table_row_t row);
        int unsigned    gap;
        machine_state_t s;
        gap = 0;
        if (!quiet && $urandom_range(0, 99) < idle_pct)
            gap = $urandom_range(1, 16);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.opcode       <= row.kind;
        in_ch.load_address <= row.addr;
        in_ch.load_word    <= row.word;
        do @(posedge i_clk); while (!in_ch.ready);
        s = apply_item(row.kind, row.addr, row.word);
        reports_due.push_back(row.typed ? row.exp : s);
    endtask

    // steps on a stopped machine change nothing and are not counted
    task automatic issue_random(input logic [KIND_W-1:0] kind,
                                input logic [LADDR_W-1:0] addr,
                                input logic [WORD_W-1:0] word);
        if (!(kind == KIND_STEP && m_status != ST_RUN))
            random_count++;
        quiet = (random_count + QUIET_ITEMS >= RANDOM_ITEMS);
        run_item(item_row(kind, addr, word));
    endtask

    function automatic void check_field(input string name, input logic [WORD_W-1:0] exp,
                                        input logic [WORD_W-1:0] got);
        if (got !== exp) begin
            $error("%s: expected 0x%08h, got 0x%08h", name, exp, got);
            fail_count++;
        end
    endfunction

    // result beats against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            beats_checked++;
            if (reports_due.size() == 0) begin
                $error("result beat with no prediction waiting");
                fail_count++;
            end else begin
                want = reports_due.pop_front();
                check_field("pc_value", want.pc, out_ch.pc_value);
                check_field("sp_value", want.sp, out_ch.sp_value);
                check_field("a_value", want.a, out_ch.a_value);
                check_field("b_value", want.b, out_ch.b_value);
                check_field("run_status", WORD_W'(want.st), WORD_W'(out_ch.run_status));
                check_field("executed_count", want.cnt, out_ch.executed_count);
            end
        end
    end

    // receiver stalls in bursts of random length
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            out_ch.ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
            stall_left <= $urandom_range(0, 15);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: %0d cycles without a beat", idle_cycles);
            $display("[two_register_cpu_step] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        table_row_t         directed_rows [$];
        logic [KIND_W-1:0]  kind;
        logic [LADDR_W-1:0] addr;
        logic [WORD_W-1:0]  word;
        logic [PLEN_W-1:0]  plen_pick;
        int unsigned        span, r, body;

        in_ch.valid        = 1'b0;
        in_ch.opcode       = KIND_REPORT;
        in_ch.load_address = '0;
        in_ch.load_word    = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.data        = '0;
        out_ch.ready       = 1'b0;
        foreach (m_data[i]) begin
            m_data[i]      = '0;
            m_code[i]      = '0;
            code_loaded[i] = 1'b0;
        end
        m_pc     = '0;
        m_sp     = '0;
        m_a      = '0;
        m_b      = '0;
        m_count  = '0;
        m_status = ST_RUN;
        m_plen   = '0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty program: a step ends at once, a stopped machine ignores steps
        directed_rows.push_back(plen_row(13'd0));
        directed_rows.push_back(check_row(KIND_REPORT, 0, 0, 0, 0, ST_RUN, 0));
        directed_rows.push_back(check_row(KIND_STEP, 0, 0, 0, 0, ST_END, 0));
        directed_rows.push_back(item_row(KIND_LOAD, 12'd0, {24'h7F_FFFF, OP_LDC}));
        directed_rows.push_back(item_row(KIND_LOAD, 12'd1, {24'h80_0000, OP_ADC}));
        directed_rows.push_back(item_row(KIND_LOAD, 12'd2, {24'h00_0000, OP_HALT}));
        directed_rows.push_back(item_row(KIND_LOAD, 12'hFFF, 32'hFFFF_FFFF));
        directed_rows.push_back(check_row(KIND_STEP, 0, 0, 0, 0, ST_END, 0));
        directed_rows.push_back(check_row(KIND_RESTART, 0, 0, 0, 0, ST_RUN, 0));
        // full store: operand extremes, halt, then a step while halted
        directed_rows.push_back(plen_row(13'd4096));
        directed_rows.push_back(item_row(KIND_STEP, '0, '0));
        directed_rows.push_back(item_row(KIND_STEP, '0, '0));
        directed_rows.push_back(check_row(KIND_STEP, 2, 0, 32'hFFFF_FFFF, 0, ST_HALT, 3));
        directed_rows.push_back(check_row(KIND_STEP, 2, 0, 32'hFFFF_FFFF, 0, ST_HALT, 3));
        directed_rows.push_back(check_row(KIND_RESTART, 0, 0, 0, 0, ST_RUN, 0));
        // set opcode is invalid
        directed_rows.push_back(item_row(KIND_LOAD, 12'd0, {24'h00_0000, OP_SET}));
        directed_rows.push_back(check_row(KIND_STEP, 0, 0, 0, 0, ST_INVALID, 1));
        directed_rows.push_back(check_row(KIND_RESTART, 0, 0, 0, 0, ST_RUN, 0));
        // local load far past the store
        directed_rows.push_back(item_row(KIND_LOAD, 12'd0, {24'h7F_FFFF, OP_LDL}));
        directed_rows.push_back(check_row(KIND_STEP, 0, 0, 0, 0, ST_BADMEM, 1));
        directed_rows.push_back(check_row(KIND_RESTART, 0, 0, 0, 0, ST_RUN, 0));
        // branch to a negative target
        directed_rows.push_back(item_row(KIND_LOAD, 12'd0, {24'h80_0000, OP_BR}));
        directed_rows.push_back(check_row(KIND_STEP, 32'hFF80_0000, 0, 0, 0, ST_PCRANGE, 1));
        directed_rows.push_back(check_row(KIND_RESTART, 0, 0, 0, 0, ST_RUN, 0));
        // branch to the top word, unknown opcode there runs off the program
        directed_rows.push_back(item_row(KIND_LOAD, 12'd0, {24'd4094, OP_BR}));
        directed_rows.push_back(item_row(KIND_STEP, '0, '0));
        directed_rows.push_back(check_row(KIND_STEP, 4096, 0, 0, 0, ST_END, 2));
        // program longer than the store: pc leaves the store without a branch
        directed_rows.push_back(plen_row('1));
        directed_rows.push_back(check_row(KIND_RESTART, 0, 0, 0, 0, ST_RUN, 0));
        directed_rows.push_back(item_row(KIND_STEP, '0, '0));
        directed_rows.push_back(item_row(KIND_STEP, '0, '0));
        directed_rows.push_back(check_row(KIND_STEP, 4096, 0, 0, 0, ST_PCRANGE, 2));

        idle_pct  = 20;
        stall_pct = 20;
        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_cfg)
                write_plen(directed_rows[i].word[PLEN_W-1:0]);
            else
                run_item(directed_rows[i]);
        end

        // random programs, one program length per phase
        while (random_count < RANDOM_ITEMS) begin
            span = $urandom_range(4, 40);
            case ($urandom_range(0, 11))
                0:       plen_pick = '0;
                1:       plen_pick = 13'd1;
                2, 3:    plen_pick = PLEN_W'(MEMORY_DEPTH);
                4:       plen_pick = '1;
                5:       plen_pick = PLEN_W'($urandom_range(0, MEMORY_DEPTH));
                default: plen_pick = PLEN_W'(span);
            endcase
            case ($urandom_range(0, 2))
                0:       idle_pct = 0;
                1:       idle_pct = 10;
                default: idle_pct = 40;
            endcase
            case ($urandom_range(0, 2))
                0:       stall_pct = 0;
                1:       stall_pct = 10;
                default: stall_pct = 40;
            endcase
            write_plen(plen_pick);
            issue_random(KIND_RESTART, LADDR_W'($urandom), $urandom);
            for (int i = 0; i < span; i++)
                issue_random(KIND_LOAD, LADDR_W'(i), rand_instr(span));

            body = $urandom_range(60, 200);
            while (body != 0 && random_count < RANDOM_ITEMS) begin
                body--;
                r = $urandom_range(0, 99);
                if (m_status != ST_RUN)
                    kind = (r < 55) ? KIND_RESTART : (r < 70) ? KIND_STEP :
                           (r < 90) ? KIND_LOAD : KIND_REPORT;
                else
                    kind = (r < 80) ? KIND_STEP : (r < 88) ? KIND_LOAD :
                           (r < 94) ? KIND_RESTART : KIND_REPORT;
                addr = LADDR_W'($urandom);
                word = $urandom;
                if (kind == KIND_LOAD) begin
                    if ($urandom_range(0, 1) != 0)
                        addr = LADDR_W'($urandom_range(0, span + 8));
                    if ($urandom_range(0, 2) != 0)
                        word = rand_instr(span);
                end
                // a fetch inside the program must find a loaded word: load it first
                if (kind == KIND_STEP && m_status == ST_RUN && m_pc < m_plen
                        && m_pc < 32'(MEMORY_DEPTH) && !code_loaded[m_pc[ADDR_W-1:0]]) begin
                    kind = KIND_LOAD;
                    addr = m_pc[ADDR_W-1:0];
                    word = rand_instr(span);
                end
                issue_random(kind, addr, word);
            end
        end

        // drain
        in_ch.valid <= 1'b0;
        while (reports_due.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("covered %0d result beats, %0d instructions executed, %0d stops",
                 beats_checked, instr_executed, stops_seen);
        $display("%0d program length writes, %0d random items", plen_writes, random_count);
        if (fail_count == 0)
            $display("[two_register_cpu_step] OK");
        else
            $display("[two_register_cpu_step] ERROR");
        $finish;
    end

endmodule

// ----- two_register_cpu_step.f -----
sv/trcpu_pkg.sv
sv/trcpu_if.sv
sv/trcpu_imem.sv
sv/trcpu_dmem.sv
sv/two_register_cpu_step.sv
dv/testbench.sv
